// ===== hw/rtl/rkst_pkg.sv =====
// shared types, codes and sizes for the range k-th smallest block
// no dependencies
package rkst_pkg;

  localparam int MaxItems  = 1024;
  localparam int NodePool  = 16384;
  localparam int RankW     = 11;
  localparam int CntW      = 11;
  localparam int LinkW     = $clog2(NodePool);
  localparam int FreeW     = LinkW + 1;
  localparam int VerW      = $clog2(MaxItems + 1);
  localparam int WantW     = 16;
  localparam int LvlW      = 4;
  localparam int StW       = 3;

  // result status codes
  localparam logic [StW-1:0] StOk    = 3'd0;
  localparam logic [StW-1:0] StRange = 3'd1;
  localparam logic [StW-1:0] StBadK  = 3'd2;
  localparam logic [StW-1:0] StRank  = 3'd3;
  localparam logic [StW-1:0] StFull  = 3'd4;

  // version root read selects
  localparam logic [1:0] VrItems = 2'd0;
  localparam logic [1:0] VrRight = 2'd1;
  localparam logic [1:0] VrLeftM = 2'd2;

  // version root capture targets
  localparam logic [1:0] VcNone = 2'd0;
  localparam logic [1:0] VcCur  = 2'd1;
  localparam logic [1:0] VcPre  = 2'd2;

  // node read address selects
  localparam logic [2:0] NrCur  = 3'd0;
  localparam logic [2:0] NrPre  = 3'd1;
  localparam logic [2:0] NrLCur = 3'd2;
  localparam logic [2:0] NrLPre = 3'd3;
  localparam logic [2:0] NrRCur = 3'd4;
  localparam logic [2:0] NrRPre = 3'd5;

  // node capture targets
  localparam logic [2:0] NcNone = 3'd0;
  localparam logic [2:0] NcCurN = 3'd1;
  localparam logic [2:0] NcPreN = 3'd2;
  localparam logic [2:0] NcLc   = 3'd3;
  localparam logic [2:0] NcLp   = 3'd4;

  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [LinkW-1:0] lft;
    logic [LinkW-1:0] rgt;
  } node_t;

  typedef struct packed {
    logic       load;
    logic       chk;
    logic [1:0] vr_sel;
    logic       vr_wr;
    logic [1:0] vr_cap;
    logic [2:0] nd_sel;
    logic [2:0] nd_cap;
    logic       app_wr;
    logic       q_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic           is_query;
    logic [StW-1:0] err;
    logic           leaf;
    logic           go_left;
  } sts_t;

endpackage

// ===== hw/rtl/rkst_ctrl.sv =====
// sequencing state machine for appends and queries
// depends on rkst_pkg
module rkst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  rkst_pkg::sts_t sts_i,
  output rkst_pkg::cmd_t cmd_o
);
  import rkst_pkg::*;

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SChk  = 4'd1;
  localparam logic [3:0] SAv   = 4'd2;
  localparam logic [3:0] SArd  = 4'd3;
  localparam logic [3:0] SAwr  = 4'd4;
  localparam logic [3:0] SQv1  = 4'd5;
  localparam logic [3:0] SQv2  = 4'd6;
  localparam logic [3:0] SQn1  = 4'd7;
  localparam logic [3:0] SQn2  = 4'd8;
  localparam logic [3:0] SQn3  = 4'd9;
  localparam logic [3:0] SQl   = 4'd10;
  localparam logic [3:0] SQl2  = 4'd11;
  localparam logic [3:0] SQl3  = 4'd12;
  localparam logic [3:0] SQd   = 4'd13;
  localparam logic [3:0] SQr   = 4'd14;
  localparam logic [3:0] SFin  = 4'd15;

  logic [3:0] state_q, state_d;
  logic       valid_q, valid_d;
  logic       r_pend_q, r_pend_d;

  assign s_ready_o = (state_q == SIdle);
  assign m_valid_o = valid_q;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    r_pend_d = r_pend_q;
    cmd_o    = '0;
    valid_d  = valid_q && !m_ready_i;
    case (state_q)
      SIdle: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SChk;
        end
      end
      SChk: begin
        cmd_o.chk = 1'b1;
        if (sts_i.err != StOk) begin
          state_d = SFin;
        end else if (sts_i.is_query) begin
          cmd_o.vr_sel = VrRight;
          state_d      = SQv1;
        end else begin
          cmd_o.vr_sel = VrItems;
          cmd_o.vr_wr  = 1'b1;
          state_d      = SAv;
        end
      end
      SAv: begin
        cmd_o.vr_cap = VcCur;
        state_d      = SArd;
      end
      SArd: begin
        cmd_o.nd_sel = NrCur;
        state_d      = SAwr;
      end
      SAwr: begin
        cmd_o.app_wr = 1'b1;
        state_d      = sts_i.leaf ? SFin : SArd;
      end
      SQv1: begin
        cmd_o.vr_cap = VcCur;
        cmd_o.vr_sel = VrLeftM;
        state_d      = SQv2;
      end
      SQv2: begin
        cmd_o.vr_cap = VcPre;
        state_d      = SQn1;
      end
      SQn1: begin
        cmd_o.nd_sel = NrCur;
        state_d      = SQn2;
      end
      SQn2: begin
        cmd_o.nd_cap = NcCurN;
        cmd_o.nd_sel = NrPre;
        state_d      = SQn3;
      end
      SQn3: begin
        cmd_o.nd_cap = NcPreN;
        state_d      = SQl;
      end
      SQl: begin
        if (sts_i.leaf) begin
          state_d = SFin;
        end else begin
          cmd_o.nd_sel = NrLCur;
          state_d      = SQl2;
        end
      end
      SQl2: begin
        cmd_o.nd_cap = NcLc;
        cmd_o.nd_sel = NrLPre;
        state_d      = SQl3;
      end
      SQl3: begin
        cmd_o.nd_cap = NcLp;
        state_d      = SQd;
      end
      SQd: begin
        cmd_o.q_step = 1'b1;
        if (sts_i.go_left) begin
          state_d = SQl;
        end else begin
          cmd_o.nd_sel = NrRCur;
          r_pend_d     = 1'b0;
          state_d      = SQr;
        end
      end
      SQr: begin
        // first capture right of cur while reading right of pre, then capture right of pre
        if (!r_pend_q) begin
          cmd_o.nd_cap = NcCurN;
          cmd_o.nd_sel = NrRPre;
          r_pend_d     = 1'b1;
        end else begin
          cmd_o.nd_cap = NcPreN;
          state_d      = SQl;
        end
      end
      SFin: begin
        if (!valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          valid_d        = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      valid_q  <= 1'b0;
      r_pend_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      r_pend_q <= r_pend_d;
    end
  end

endmodule

// ===== hw/rtl/rkst_dp.sv =====
// datapath: node pool, version roots, item checks and the tree walk
// depends on rkst_pkg
module rkst_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [rkst_pkg::RankW-1:0] cfg_wdata_i,
  input  logic                    req_type_i,
  input  logic [rkst_pkg::RankW-1:0] value_rank_i,
  input  logic [rkst_pkg::RankW-1:0] range_left_i,
  input  logic [rkst_pkg::RankW-1:0] range_right_i,
  input  logic [rkst_pkg::RankW-1:0] order_k_i,
  input  rkst_pkg::cmd_t           cmd_i,
  output rkst_pkg::sts_t           sts_o,
  output logic [rkst_pkg::RankW-1:0] result_rank_o,
  output logic [rkst_pkg::StW-1:0]   status_o
);
  import rkst_pkg::*;

  // memories
  node_t            pool_mem [NodePool];
  logic [LinkW-1:0] vr_mem   [MaxItems+1];

  logic [RankW-1:0] leaf_q;
  logic [LvlW-1:0]  lvl_q;
  logic [VerW-1:0]  items_q;
  logic [FreeW-1:0] free_q;
  logic             req_q;
  logic [RankW-1:0] rank_q, l_q, r_q, k_q;
  logic [StW-1:0]   err_q;
  logic [RankW-1:0] lo_q, hi_q;
  logic [FreeW-1:0] node_q;
  logic [LinkW-1:0] cur_q, pre_q;
  node_t            curn_q, pren_q, lc_q, lp_q;
  logic signed [WantW-1:0] want_q;

  node_t            nd_raw_q, nd_rd;
  logic             nd_zero_q;
  logic [LinkW-1:0] vr_raw_q, vr_rd;
  logic             vr_zero_q;

  logic [RankW-1:0] eff, cfg_eff, cfg_m1;
  logic [LvlW-1:0]  cfg_lvl;
  logic [RankW:0]   mid_sum;
  logic [RankW-1:0] mid;
  logic [FreeW-1:0] fresh;
  logic [LinkW-1:0] nd_addr;
  logic [VerW-1:0]  vr_addr;
  logic [StW-1:0]   err;
  logic [RankW:0]   span;
  logic [FreeW:0]   need;
  logic signed [WantW-1:0] ase;
  node_t            wr_node;

  assign eff     = (leaf_q == '0) ? RankW'(1) : leaf_q;
  assign cfg_eff = (cfg_wdata_i == '0) ? RankW'(1) : cfg_wdata_i;
  assign cfg_m1  = cfg_eff - RankW'(1);

  // level count of a new leaf count: bit length of leaves-1, plus one
  always_comb begin
    cfg_lvl = LvlW'(1);
    for (int i = 0; i < RankW; i++) begin
      if (cfg_m1[i]) cfg_lvl = LvlW'(i + 2);
    end
  end

  // item checks
  assign span = {1'b0, r_q} - {1'b0, l_q} + (RankW+1)'(1);
  assign need = {1'b0, free_q} + (FreeW+1)'(lvl_q);
  always_comb begin
    err = StOk;
    if (req_q) begin
      if (l_q == '0 || l_q > r_q || {1'b0, r_q} > (RankW+1)'(items_q)) err = StRange;
      else if (k_q == '0 || {1'b0, k_q} > span) err = StBadK;
    end else begin
      if (rank_q == '0 || rank_q > eff) err = StRank;
      else if ((VerW+1)'(items_q) >= (VerW+1)'(MaxItems)) err = StFull;
      else if (need > (FreeW+1)'(NodePool)) err = StFull;
    end
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[RankW:1];
  assign fresh   = node_q + FreeW'(1);
  assign ase     = WantW'(lc_q.cnt) - WantW'(lp_q.cnt);

  assign sts_o.is_query = req_q;
  assign sts_o.err      = err;
  assign sts_o.leaf     = (lo_q >= hi_q);
  assign sts_o.go_left  = (ase >= want_q);

  // read address selects
  always_comb begin
    case (cmd_i.vr_sel)
      VrRight: vr_addr = VerW'(r_q);
      VrLeftM: vr_addr = VerW'(l_q - RankW'(1));
      default: vr_addr = items_q;
    endcase
    case (cmd_i.nd_sel)
      NrPre:  nd_addr = pre_q;
      NrLCur: nd_addr = curn_q.lft;
      NrLPre: nd_addr = pren_q.lft;
      NrRCur: nd_addr = curn_q.rgt;
      NrRPre: nd_addr = pren_q.rgt;
      default: nd_addr = cur_q;
    endcase
  end

  // entry zero of each store reads as the empty tree
  assign nd_rd = nd_zero_q ? '0 : nd_raw_q;
  assign vr_rd = vr_zero_q ? '0 : vr_raw_q;

  // appended node from the old node
  always_comb begin
    wr_node.cnt = nd_rd.cnt + CntW'(1);
    wr_node.lft = nd_rd.lft;
    wr_node.rgt = nd_rd.rgt;
    if (lo_q < hi_q) begin
      if (rank_q <= mid) wr_node.lft = fresh[LinkW-1:0];
      else               wr_node.rgt = fresh[LinkW-1:0];
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    nd_raw_q  <= pool_mem[nd_addr];
    nd_zero_q <= (nd_addr == '0);
    vr_raw_q  <= vr_mem[vr_addr];
    vr_zero_q <= (vr_addr == '0);
    if (cmd_i.app_wr) pool_mem[node_q[LinkW-1:0]] <= wr_node;
    if (cmd_i.vr_wr)  vr_mem[items_q + VerW'(1)] <= free_q[LinkW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_q  <= RankW'(MaxItems);
      lvl_q   <= LvlW'($clog2(MaxItems) + 1);
      items_q <= '0;
      free_q  <= FreeW'(1);
    end else begin
      if (cfg_we_i) begin
        leaf_q <= cfg_wdata_i;
        lvl_q  <= cfg_lvl;
      end
      if (cmd_i.app_wr && lo_q >= hi_q) begin
        items_q <= items_q + VerW'(1);
        free_q  <= fresh;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      rank_q <= value_rank_i;
      l_q    <= range_left_i;
      r_q    <= range_right_i;
      k_q    <= order_k_i;
    end
    if (cmd_i.chk) begin
      err_q  <= err;
      lo_q   <= RankW'(1);
      hi_q   <= eff;
      node_q <= free_q;
      want_q <= WantW'(k_q);
    end
    case (cmd_i.vr_cap)
      VcCur:   cur_q <= vr_rd;
      VcPre:   pre_q <= vr_rd;
      default: ;
    endcase
    case (cmd_i.nd_cap)
      NcCurN:  curn_q <= nd_rd;
      NcPreN:  pren_q <= nd_rd;
      NcLc:    lc_q   <= nd_rd;
      NcLp:    lp_q   <= nd_rd;
      default: ;
    endcase
    if (cmd_i.app_wr && lo_q < hi_q) begin
      node_q <= fresh;
      if (rank_q <= mid) begin
        cur_q <= nd_rd.lft;
        hi_q  <= mid;
      end else begin
        cur_q <= nd_rd.rgt;
        lo_q  <= mid + RankW'(1);
      end
    end
    if (cmd_i.q_step) begin
      if (ase >= want_q) begin
        curn_q <= lc_q;
        pren_q <= lp_q;
        hi_q   <= mid;
      end else begin
        want_q <= want_q - ase;
        lo_q   <= mid + RankW'(1);
      end
    end
    if (cmd_i.out_load) begin
      status_o      <= err_q;
      result_rank_o <= (req_q && err_q == StOk) ? lo_q : '0;
    end
  end

endmodule

// ===== hw/rtl/range_kth_smallest_persistent_tree.sv =====
// Range k-th smallest over appended ranks, one item in flight at a time.
// Tree levels L = bit length of leaf_count-1, plus 1. An append reads and writes one node pool
// entry per level along its path; a query walks at most L-1 steps, each a left or a right
// step, on a single pool read port; errors skip the walk.
// The next item can be accepted in the same cycle its result shows; a held result stalls the next result.
// Reset is asynchronous active low: empty store, leaf_count 1024, no pool clear.
module range_kth_smallest_persistent_tree (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,     // leaf_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,         // value_rank, range_left, range_right, order_k, pad
  input  logic [0:0]  s_tuser,         // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata          // result_rank, status, pad
);
  import rkst_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [RankW-1:0] rank;
  logic [StW-1:0]   status;

  rkst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_tvalid),
    .s_ready_o (s_tready),
    .m_valid_o (m_tvalid),
    .m_ready_i (m_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rkst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (s_tuser[0]),
    .value_rank_i  (s_tdata[10:0]),
    .range_left_i  (s_tdata[21:11]),
    .range_right_i (s_tdata[32:22]),
    .order_k_i     (s_tdata[43:33]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_rank_o (rank),
    .status_o      (status)
  );

  assign m_tdata = {2'b00, status, rank};

endmodule

// ===== hw/rtl/rkst_checker.sv =====
// port level checks for the range k-th smallest block, bound to the top
// depends on the top level ports only
module rkst_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // status code in range
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[13:11] <= 3'd4)
    else $error("status code out of range");

  // an error carries rank zero
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[13:11] != 3'd0 |-> m_tdata[10:0] == 11'd0)
    else $error("error item with nonzero rank");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready while busy");

endmodule

bind range_kth_smallest_persistent_tree rkst_props u_rkst_props (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/rkst_checker.sv =====
// checker for the range k-th smallest block: watches both item channels,
// predicts each result with its own persistent count tree and compares
// depends on rkst_pkg and the block's stream ports
module rkst_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import rkst_pkg::*;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [StW-1:0]   st;
  } answer_t;

  // predictor state: pool of count nodes and version roots
  logic [CntW-1:0]  pool_cnt [NodePool];
  logic [LinkW-1:0] pool_lft [NodePool];
  logic [LinkW-1:0] pool_rgt [NodePool];
  logic [LinkW-1:0] roots [MaxItems+1];
  int unsigned      loaded;
  int unsigned      free_node;
  logic [10:0]      leaves_reg;

  // expected results in order, small ring
  answer_t          due_mem [16];
  int               due_wr;
  int               due_rd;

  function automatic int unsigned tree_levels(int unsigned leaves);
    int unsigned lo, hi, n;
    lo = 1; hi = leaves; n = 1;
    while (lo < hi) begin
      hi = (lo + hi) >> 1;
      n++;
    end
    return n;
  endfunction

  // one append: clone one node per level along the path to the leaf
  function automatic logic [StW-1:0] add_rank(int unsigned rank);
    int unsigned leaves, lo, hi, old, nd, mid, fresh;
    leaves = (leaves_reg == 0) ? 1 : leaves_reg;
    lo = 1; hi = leaves;
    if (rank < 1 || rank > leaves) return StRank;
    if (loaded >= MaxItems) return StFull;
    if (free_node + tree_levels(leaves) > NodePool) return StFull;
    old = roots[loaded];
    nd = free_node++;
    roots[loaded+1] = nd;
    forever begin
      pool_cnt[nd] = pool_cnt[old] + 1'b1;
      if (lo >= hi) begin
        pool_lft[nd] = pool_lft[old];
        pool_rgt[nd] = pool_rgt[old];
        break;
      end
      mid = (lo + hi) >> 1;
      fresh = free_node++;
      if (rank <= mid) begin
        pool_rgt[nd] = pool_rgt[old];
        pool_lft[nd] = fresh;
        old = pool_lft[old];
        hi = mid;
      end else begin
        pool_lft[nd] = pool_lft[old];
        pool_rgt[nd] = fresh;
        old = pool_rgt[old];
        lo = mid + 1;
      end
      nd = fresh;
    end
    loaded++;
    return StOk;
  endfunction

  // one query: walk versions right and left-1 side by side
  function automatic answer_t find_kth(int unsigned l, int unsigned r, int unsigned k);
    answer_t a;
    int unsigned lo, hi, pre, cur, mid;
    int want, diff;
    a = '0;
    if (l < 1 || l > r || r > loaded) begin
      a.st = StRange;
      return a;
    end
    if (k < 1 || k > r - l + 1) begin
      a.st = StBadK;
      return a;
    end
    lo = 1; hi = (leaves_reg == 0) ? 1 : leaves_reg;
    pre = roots[l-1]; cur = roots[r]; want = k;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      diff = int'(pool_cnt[pool_lft[cur]]) - int'(pool_cnt[pool_lft[pre]]);
      if (diff >= want) begin
        pre = pool_lft[pre]; cur = pool_lft[cur]; hi = mid;
      end else begin
        want -= diff;
        pre = pool_rgt[pre]; cur = pool_rgt[cur]; lo = mid + 1;
      end
    end
    a.rank = lo[RankW-1:0];
    a.st = StOk;
    return a;
  endfunction

  assign pending = due_wr - due_rd;

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want_a, got_a;
    if (!rst_ni) begin
      pool_cnt[0] = '0; pool_lft[0] = '0; pool_rgt[0] = '0;
      roots[0] = '0;
      loaded = 0; free_node = 1; leaves_reg = 11'd1024;
      due_wr = 0;
      due_rd = 0;
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      // result side first: it was produced from earlier items
      if (m_tvalid && m_tready) begin
        got_a.rank = m_tdata[10:0];
        got_a.st = m_tdata[13:11];
        results_seen <= results_seen + 1;
        if (due_wr == due_rd) begin
          if (fail_count < 10) $display("unexpected result item %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want_a = due_mem[due_rd[3:0]];
          due_rd++;
          if (want_a != got_a) begin
            if (fail_count < 10)
              $display("mismatch: expected rank %0d status %0d, got rank %0d status %0d",
                       want_a.rank, want_a.st, got_a.rank, got_a.st);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we_i) leaves_reg = cfg_wdata_i;
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == 1'b0) begin
          want_a = '0;
          want_a.st = add_rank(s_tdata[10:0]);
        end else begin
          want_a = find_kth(s_tdata[21:11], s_tdata[32:22], s_tdata[43:33]);
        end
        due_mem[due_wr[3:0]] = want_a;
        due_wr++;
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// stimulus and verdict for the range k-th smallest block
// depends on rkst_pkg, the block and rkst_checker
module tb;
  import rkst_pkg::*;

  localparam logic ReqAppend = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  int          fail_count, pending, results_seen;

  int          send_idle_pct = 29;
  int          recv_idle_pct = 74;
  int          items_sent = 0;
  int unsigned loaded_model = 0;
  int unsigned leaves_now = 1024;

  always #5 clk_i = ~clk_i;

  range_kth_smallest_persistent_tree DUT (.*);

  rkst_checker u_checker (.*);

  // receiver stalls at random
  always @(negedge clk_i)
    m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // hand one item to the block, with a random gap before it
  // valid stays up after the accept until the next item or a drain
  task automatic send_item(logic kind, int unsigned rank, int unsigned l,
                           int unsigned r, int unsigned k);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'b0, k[10:0], r[10:0], l[10:0], rank[10:0]};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    // mirror the loaded count to aim queries at valid ranges
    if (kind == ReqAppend && rank >= 1 && rank <= leaves_now && loaded_model < MaxItems)
      loaded_model++;
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_leaves(int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[10:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    leaves_now = (v == 0) ? 1 : v;
  endtask

  task automatic random_query();
    int unsigned l, r;
    if (loaded_model == 0 || $urandom_range(9) == 0) begin
      send_item(ReqQuery, $urandom, $urandom_range(2047), $urandom_range(2047),
                $urandom_range(2047));
      return;
    end
    l = $urandom_range(loaded_model, 1);
    r = $urandom_range(loaded_model, l);
    send_item(ReqQuery, $urandom, l, r, $urandom_range(r - l + 1, 1));
  endtask

  task automatic random_phase(int n, int unsigned maxrank);
    repeat (n) begin
      if ($urandom_range(99) < 45 && loaded_model < MaxItems) begin
        if ($urandom_range(19) == 0) send_item(ReqAppend, $urandom_range(2047), 0, 0, 0);
        else send_item(ReqAppend, $urandom_range(maxrank, 1), 0, 0, 0);
      end else begin
        random_query();
      end
    end
  endtask

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty-store queries, rank extremes, bad k and range
    send_item(ReqQuery, 0, 1, 1, 1);
    send_item(ReqAppend, 0, 0, 0, 0);
    send_item(ReqAppend, 1025, 0, 0, 0);
    send_item(ReqAppend, 2047, 0, 0, 0);
    send_item(ReqAppend, 1024, 0, 0, 0);
    send_item(ReqAppend, 1, 0, 0, 0);
    send_item(ReqAppend, 512, 0, 0, 0);
    send_item(ReqQuery, 0, 0, 2, 1);
    send_item(ReqQuery, 0, 3, 2, 1);
    send_item(ReqQuery, 0, 1, 4, 1);
    send_item(ReqQuery, 0, 1, 3, 0);
    send_item(ReqQuery, 0, 1, 3, 4);
    send_item(ReqQuery, 0, 1, 3, 1);
    send_item(ReqQuery, 0, 1, 3, 3);
    send_item(ReqQuery, 0, 2, 3, 2);
    send_item(ReqQuery, 0, 2047, 2047, 2047);
    drain();

    // small tree, leaf count changed mid-load, then zero acting as one
    send_idle_pct = 29; recv_idle_pct = 74;
    set_leaves(7);
    random_phase(200, 7);
    drain();
    set_leaves(1);
    random_phase(60, 1);
    drain();
    set_leaves(0);
    random_phase(40, 1);
    drain();

    send_idle_pct = 74; recv_idle_pct = 29;
    set_leaves(2047);
    random_phase(150, 2047);
    drain();
    set_leaves(100);
    random_phase(200, 100);
    drain();

    // fill the store to exercise store full
    send_idle_pct = 0; recv_idle_pct = 0;
    set_leaves(1024);
    random_phase(150, 1024);
    while (loaded_model < MaxItems) send_item(ReqAppend, $urandom_range(1024, 1), 0, 0, 0);
    send_item(ReqAppend, 5, 0, 0, 0);
    random_phase(100, 1024);
    drain();

    $display("sent %0d items, checked %0d results, leaf counts 0 to 2047",
             items_sent, results_seen);
    $display("store filled to capacity, error codes and queries mixed");
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
